// ===== rtl/okvt_pkg.sv =====
// shared types and operation codes for the ordered key/value table
`timescale 1ns / 1ps
package okvt_pkg;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_UPDATE   = 3'd1,
		OP_UPSERT   = 3'd2,
		OP_ERASE    = 3'd3,
		OP_CONTAINS = 3'd4,
		OP_GET_KEY  = 3'd5,
		OP_GET_POS  = 3'd6
	} okvt_kind_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [63:0] value;
		logic [7:0]  position;
	} okvt_req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] found_key;
		logic [63:0] found_value;
		logic [8:0]  entry_count;
		logic        is_empty;
	} okvt_rsp_t;

	// control part of the token that walks down the chain
	typedef struct packed {
		logic active;
		logic hit;
		logic appended;
	} okvt_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} okvt_state_e;

endpackage

// ===== rtl/okvt_cell.sv =====
// one table entry: holds a key/value pair and acts on the token passing by
`timescale 1ns / 1ps
module okvt_cell import okvt_pkg::*; #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64,
	parameter int CNT_W      = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  okvt_kind_e            kind,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [7:0]            pos,
	input  logic [CNT_W-1:0]      count,
	input  okvt_ctrl_t            tok_i,
	input  logic [CNT_W-1:0]      idx_i,
	input  logic [KEY_BITS-1:0]   fkey_i,
	input  logic [VALUE_BITS-1:0] fval_i,
	input  logic [KEY_BITS-1:0]   nb_key,
	input  logic [VALUE_BITS-1:0] nb_value,
	output okvt_ctrl_t            tok_o,
	output logic [CNT_W-1:0]      idx_o,
	output logic [KEY_BITS-1:0]   fkey_o,
	output logic [VALUE_BITS-1:0] fval_o,
	output logic [KEY_BITS-1:0]   own_key,
	output logic [VALUE_BITS-1:0] own_value
);

	localparam int PW = (CNT_W > 8) ? CNT_W : 8;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	okvt_ctrl_t            tok_q;
	logic [CNT_W-1:0]      idx_q;
	logic [KEY_BITS-1:0]   fkey_q;
	logic [VALUE_BITS-1:0] fval_q;

	logic                  occ;
	logic                  match;
	logic                  at_end;
	logic                  pos_hit;
	okvt_ctrl_t            tok_d;
	logic [KEY_BITS-1:0]   fkey_d;
	logic [VALUE_BITS-1:0] fval_d;
	logic                  wr_key;
	logic                  wr_value;
	logic                  shift;
	logic [KEY_BITS-1:0]   key_d;
	logic [VALUE_BITS-1:0] value_d;

	assign occ     = idx_i < count;
	assign match   = occ && (key_q == key) && !tok_i.hit;
	assign at_end  = (idx_i == count) && !tok_i.hit;
	assign pos_hit = occ && (PW'(idx_i) == PW'(pos));

	always_comb begin
		tok_d    = tok_i;
		fkey_d   = fkey_i;
		fval_d   = fval_i;
		wr_key   = 1'b0;
		wr_value = 1'b0;
		shift    = 1'b0;
		unique case (kind)
			OP_INSERT: begin
				if (match) begin
					tok_d.hit = 1'b1;
				end else if (at_end) begin
					wr_key         = 1'b1;
					wr_value       = 1'b1;
					tok_d.appended = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (match) begin
					tok_d.hit = 1'b1;
					wr_value  = 1'b1;
				end
			end
			OP_UPSERT: begin
				if (match) begin
					tok_d.hit = 1'b1;
					wr_value  = 1'b1;
				end else if (at_end && !tok_i.appended) begin
					wr_key         = 1'b1;
					wr_value       = 1'b1;
					tok_d.appended = 1'b1;
				end
			end
			OP_ERASE: begin
				// matching entry and every later occupied one pull in their right neighbor
				if (match) begin
					tok_d.hit = 1'b1;
					shift     = 1'b1;
				end else if (tok_i.hit && occ) begin
					shift = 1'b1;
				end
			end
			OP_CONTAINS: begin
				if (match) begin
					tok_d.hit = 1'b1;
				end
			end
			OP_GET_KEY: begin
				if (match) begin
					tok_d.hit = 1'b1;
					fval_d    = value_q;
				end
			end
			OP_GET_POS: begin
				if (pos_hit) begin
					tok_d.hit = 1'b1;
					fkey_d    = key_q;
					fval_d    = value_q;
				end
			end
			default: begin
			end
		endcase
		if (!tok_i.active) begin
			wr_key   = 1'b0;
			wr_value = 1'b0;
			shift    = 1'b0;
		end
		key_d   = shift ? nb_key : key;
		value_d = shift ? nb_value : value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_i + CNT_W'(1);
		fkey_q <= fkey_d;
		fval_q <= fval_d;
		if (wr_key || shift) begin
			key_q <= key_d;
		end
		if (wr_value || shift) begin
			value_q <= value_d;
		end
	end

	assign tok_o     = tok_q;
	assign idx_o     = idx_q;
	assign fkey_o    = fkey_q;
	assign fval_o    = fval_q;
	assign own_key   = key_q;
	assign own_value = value_q;

endmodule

// ===== rtl/ordered_key_value_table_core.sv =====
// top level of the ordered key/value table: command port, entry chain, result
`timescale 1ns / 1ps
// Ordered key/value table, up to CAPACITY entries kept in insertion order.
// A command word (kind, key, value, position) is taken at a rising edge with
// start high and busy low. busy then stays high up to and including the
// cycle in which the result is shown.
// The command travels as a token along a row of CAPACITY entry cells, one
// cell per clock; each cell compares, writes, or pulls in its right
// neighbor (erase compaction) as the token passes.
// The result word (ok, found key and value, entry count, empty flag) is
// on the result port for exactly one cycle with done high; it is taken at
// the edge that ends that cycle and cannot be held off.
// One command at a time: the token enters the first cell, walks the cell row
// while the state is SCAN, and the result is registered and done raised as
// the token leaves the last cell; a new command is taken only once the DONE
// state has passed and busy is low again.
// Reset clears the entry count and the control state; entry contents are
// not cleared, entries at or beyond the count are never read out.
module ordered_key_value_table_core import okvt_pkg::*; #(
	parameter int CAPACITY   = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  okvt_req_t request,
	output logic      done,
	output okvt_rsp_t result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	okvt_state_e            state_q;
	okvt_req_t              req_q;
	logic                   inj_q;
	logic [CNT_W-1:0]       count_q;
	okvt_rsp_t              rsp_q;

	okvt_kind_e             kind;
	logic [KEY_BITS-1:0]    key_w;
	logic [VALUE_BITS-1:0]  value_w;

	okvt_ctrl_t             ctrl_c [CAPACITY+1];
	logic [CNT_W-1:0]       idx_c  [CAPACITY+1];
	logic [KEY_BITS-1:0]    fkey_c [CAPACITY+1];
	logic [VALUE_BITS-1:0]  fval_c [CAPACITY+1];
	logic [KEY_BITS-1:0]    key_c  [CAPACITY];
	logic [VALUE_BITS-1:0]  val_c  [CAPACITY];

	okvt_ctrl_t             tail;
	logic                   res_ok;
	logic [CNT_W-1:0]       count_d;
	logic                   accept;

	assign accept  = start && !busy;
	assign kind    = okvt_kind_e'(req_q.kind);
	assign key_w   = KEY_BITS'(req_q.key);
	assign value_w = VALUE_BITS'(req_q.value);

	assign ctrl_c[0] = '{active: inj_q, hit: 1'b0, appended: 1'b0};
	assign idx_c[0]  = '0;
	assign fkey_c[0] = '0;
	assign fval_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]   nb_key;
		logic [VALUE_BITS-1:0] nb_value;

		if (i < CAPACITY - 1) begin : g_nb
			assign nb_key   = key_c[i+1];
			assign nb_value = val_c[i+1];
		end else begin : g_last
			assign nb_key   = '0;
			assign nb_value = '0;
		end

		okvt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.kind      (kind),
			.key       (key_w),
			.value     (value_w),
			.pos       (req_q.position),
			.count     (count_q),
			.tok_i     (ctrl_c[i]),
			.idx_i     (idx_c[i]),
			.fkey_i    (fkey_c[i]),
			.fval_i    (fval_c[i]),
			.nb_key    (nb_key),
			.nb_value  (nb_value),
			.tok_o     (ctrl_c[i+1]),
			.idx_o     (idx_c[i+1]),
			.fkey_o    (fkey_c[i+1]),
			.fval_o    (fval_c[i+1]),
			.own_key   (key_c[i]),
			.own_value (val_c[i])
		);
	end

	assign tail = ctrl_c[CAPACITY];

	always_comb begin
		res_ok  = 1'b0;
		count_d = count_q;
		unique case (kind) inside
			OP_INSERT: begin
				res_ok = tail.appended;
			end
			OP_UPDATE, OP_CONTAINS, OP_GET_KEY, OP_GET_POS: begin
				res_ok = tail.hit;
			end
			OP_UPSERT: begin
				res_ok = tail.hit || tail.appended;
			end
			OP_ERASE: begin
				res_ok = tail.hit;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
		if (tail.appended) begin
			count_d = count_q + CNT_W'(1);
		end else if (kind == OP_ERASE && tail.hit) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inj_q   <= 1'b0;
			count_q <= '0;
		end else begin
			inj_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						inj_q   <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.active) begin
						count_q <= count_d;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == ST_SCAN && tail.active) begin
			rsp_q.ok          <= res_ok;
			rsp_q.found_key   <= 32'(fkey_c[CAPACITY]);
			rsp_q.found_value <= 64'(fval_c[CAPACITY]);
			rsp_q.entry_count <= 9'(count_d);
			rsp_q.is_empty    <= (count_d == '0);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = rsp_q;

endmodule
